[rtl/brrb_pkg.sv]
// ----------------------------------------------------------------------------
// brrb_pkg
// Shared types and constants of the byte ring record buffer: request and
// response items, status codes, the command that passes from front to back.
// ----------------------------------------------------------------------------
package brrb_pkg;

   localparam int RING_BYTES_DEF = 4096;
   localparam int MAX_RECORD_DEF = 64;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NO_ROOM = 3'd1,
      ST_NO_DATA = 3'd2,
      ST_BAD_LEN = 3'd3,
      ST_STRAY   = 3'd4
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

   typedef struct packed {
      logic       op;
      logic [6:0] length;
      logic       first;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  data_out;
      logic        byte_valid;
      logic        last;
      logic [12:0] free_space;
      logic [11:0] stored_count;
   } rsp_type;

   // Work handed from the classifier to the executor. A command that is not a
   // read produces exactly one response; a read produces length responses.
   typedef struct packed {
      logic        is_read;
      status_type  status;
      logic [6:0]  length;
      logic [12:0] free_space;
      logic [11:0] stored_count;
   } cmd_type;

endpackage

[rtl/brrb_ram.sv]
// ----------------------------------------------------------------------------
// brrb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module brrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/brrb_queue.sv]
// ----------------------------------------------------------------------------
// brrb_queue
// Two-entry command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module brrb_queue import brrb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty,
   output logic    full
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);

endmodule

[rtl/brrb_front.sv]
// ----------------------------------------------------------------------------
// brrb_front
// Request classifier. Owns the ring pointers and the record state, writes
// pushed bytes into the store and queues one command per request.
// ----------------------------------------------------------------------------
module brrb_front import brrb_pkg::*; #(
   parameter int RING_BYTES = RING_BYTES_DEF,
   parameter int MAX_RECORD = MAX_RECORD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  req_type                       req_item,
   output logic                          busy,
   input  logic                          queue_full,
   input  logic                          pop_done,
   output logic                          enq,
   output cmd_type                       enq_cmd,
   output logic                          ram_we,
   output logic [$clog2(RING_BYTES)-1:0] ram_waddr,
   output logic [7:0]                    ram_wdata
);

   localparam int PTR_W = $clog2(RING_BYTES);
   localparam int CNT_W = $clog2(RING_BYTES + 1);
   localparam int SUM_W = PTR_W + 1;

   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] stg_ff, stg_in;
   logic [6:0]       rem_ff, rem_in;
   logic             acc_ff, acc_in;
   logic             pop_pend_ff, pop_pend_in;

   logic [CNT_W-1:0] cur_free, cur_stored, new_free;
   logic [6:0]       len;
   logic             len_bad;
   logic [PTR_W-1:0] store_addr, store_next;
   logic [SUM_W-1:0] rd_sum;
   status_type       status;
   logic             is_read;

   function automatic logic [CNT_W-1:0] ring_free(input logic [PTR_W-1:0] wp,
                                                  input logic [PTR_W-1:0] rp);
      if (wp >= rp) begin
         return CNT_W'(RING_BYTES) - CNT_W'(wp) + CNT_W'(rp);
      end
      return CNT_W'(rp) - CNT_W'(wp);
   endfunction

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      len        = req_item.length;
      len_bad    = (len == 7'd0) || (len > 7'(MAX_RECORD));
      cur_free   = ring_free(wr_ff, rd_ff);
      cur_stored = CNT_W'(RING_BYTES) - cur_free;
      store_addr = req_item.first ? wr_ff : stg_ff;
      store_next = ring_next(store_addr);
      rd_sum     = SUM_W'(rd_ff) + SUM_W'(len);

      rd_in   = rd_ff;
      wr_in   = wr_ff;
      stg_in  = stg_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      status  = ST_OK;
      is_read = 1'b0;
      ram_we  = 1'b0;

      if (req_item.op == OP_PUSH) begin
         if (req_item.first) begin
            rem_in = 7'd0;
            acc_in = 1'b0;
            if (len_bad) begin
               status = ST_BAD_LEN;
            end else if (32'(cur_free) <= 32'(len)) begin
               rem_in = len - 7'd1;
               status = ST_NO_ROOM;
            end else begin
               ram_we = 1'b1;
               stg_in = store_next;
               rem_in = len - 7'd1;
               if (len == 7'd1) begin
                  wr_in = store_next;
               end else begin
                  acc_in = 1'b1;
               end
            end
         end else if (rem_ff == 7'd0) begin
            status = ST_STRAY;
         end else if (acc_ff) begin
            ram_we = 1'b1;
            stg_in = store_next;
            rem_in = rem_ff - 7'd1;
            if (rem_ff == 7'd1) begin
               wr_in  = store_next;
               acc_in = 1'b0;
            end
         end else begin
            rem_in = rem_ff - 7'd1;
            status = ST_NO_ROOM;
         end
      end else begin
         if (len == 7'd0) begin
            status = ST_OK;
         end else if (len_bad) begin
            status = ST_BAD_LEN;
         end else if (32'(cur_stored) < 32'(len)) begin
            status = ST_NO_DATA;
         end else begin
            is_read = 1'b1;
            rd_in   = (rd_sum >= SUM_W'(RING_BYTES)) ?
                      PTR_W'(rd_sum - SUM_W'(RING_BYTES)) : PTR_W'(rd_sum);
         end
      end

      new_free = ring_free(wr_in, rd_in);

      enq_cmd.is_read      = is_read;
      enq_cmd.status       = status;
      enq_cmd.length       = len;
      enq_cmd.free_space   = 13'(new_free);
      enq_cmd.stored_count = 12'(32'(RING_BYTES) - 32'(new_free));

      busy        = queue_full | pop_pend_ff;
      enq         = start & ~busy;
      ram_we      = ram_we & enq;
      ram_waddr   = store_addr;
      ram_wdata   = req_item.data_in;
      pop_pend_in = pop_done ? 1'b0 : (pop_pend_ff | (enq & is_read));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff       <= '0;
         wr_ff       <= '0;
         stg_ff      <= '0;
         rem_ff      <= 7'd0;
         acc_ff      <= 1'b0;
         pop_pend_ff <= 1'b0;
      end else begin
         pop_pend_ff <= pop_pend_in;
         if (enq) begin
            rd_ff  <= rd_in;
            wr_ff  <= wr_in;
            stg_ff <= stg_in;
            rem_ff <= rem_in;
            acc_ff <= acc_in;
         end
      end
   end

endmodule

[rtl/brrb_back.sv]
// ----------------------------------------------------------------------------
// brrb_back
// Command executor. Emits single responses and streams popped bytes out of
// the store, one per cycle, through the registered read port.
// ----------------------------------------------------------------------------
module brrb_back import brrb_pkg::*; #(
   parameter int RING_BYTES = RING_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       head_cmd,
   input  logic                          queue_empty,
   output logic                          deq,
   output logic                          pop_done,
   output logic                          ram_re,
   output logic [$clog2(RING_BYTES)-1:0] ram_raddr,
   input  logic [7:0]                    ram_q,
   output logic                          rsp_strobe,
   output rsp_type                       rsp_item
);

   localparam int PTR_W = $clog2(RING_BYTES);

   back_state_type   state_ff, state_in;
   logic [PTR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;
   status_type       out_status_ff, out_status_in;
   logic [12:0]      out_free_ff, out_free_in;
   logic [11:0]      out_stored_ff, out_stored_in;

   always_comb begin
      state_in      = state_ff;
      rd_addr_in    = rd_addr_ff;
      cnt_in        = cnt_ff;
      out_valid_in  = 1'b0;
      out_byte_in   = 1'b0;
      out_last_in   = 1'b1;
      out_status_in = out_status_ff;
      out_free_in   = out_free_ff;
      out_stored_in = out_stored_ff;
      deq           = 1'b0;
      pop_done      = 1'b0;
      ram_re        = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               deq           = 1'b1;
               out_free_in   = head_cmd.free_space;
               out_stored_in = head_cmd.stored_count;
               out_status_in = head_cmd.status;
               if (head_cmd.is_read) begin
                  cnt_in   = head_cmd.length;
                  state_in = BK_READ;
               end else begin
                  out_valid_in = 1'b1;
               end
            end
         end
         BK_READ: begin
            ram_re       = 1'b1;
            rd_addr_in   = (rd_addr_ff == PTR_W'(RING_BYTES - 1)) ?
                           '0 : rd_addr_ff + PTR_W'(1);
            cnt_in       = cnt_ff - 7'd1;
            out_valid_in = 1'b1;
            out_byte_in  = 1'b1;
            out_last_in  = (cnt_ff == 7'd1);
            if (cnt_ff == 7'd1) begin
               pop_done = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_addr_ff   <= '0;
         cnt_ff       <= 7'd0;
         out_valid_ff <= 1'b0;
         out_byte_ff  <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_addr_ff   <= rd_addr_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         out_byte_ff  <= out_byte_in;
         out_last_ff  <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_free_ff   <= out_free_in;
      out_stored_ff <= out_stored_in;
   end

   assign ram_raddr = rd_addr_ff;

   assign rsp_strobe            = out_valid_ff;
   assign rsp_item.status       = out_status_ff;
   assign rsp_item.data_out     = out_byte_ff ? ram_q : 8'd0;
   assign rsp_item.byte_valid   = out_byte_ff;
   assign rsp_item.last         = out_last_ff;
   assign rsp_item.free_space   = out_free_ff;
   assign rsp_item.stored_count = out_stored_ff;

endmodule

[rtl/byte_ring_record_buffer.sv]
// ----------------------------------------------------------------------------
// byte_ring_record_buffer
// Circular byte store with all-or-nothing record pushes and block pops.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Handshake
//   --------  ---------------------------  --------------------------------
//   request   start, busy, req_item        taken when start=1 and busy=0
//   response  rsp_strobe, rsp_item         each strobe is one response, no stall
//
// Push bytes may follow each other in consecutive cycles while busy is low;
// each push answers through a queue entry and the back's output registers.
// A pop of N bytes keeps busy high from the cycle after it is taken until
// its last store read is issued, so the next request waits for the whole
// pop; the bytes come out one per cycle over the store's read port.
// Reset is synchronous and active high; the store itself is not cleared.
// The response side cannot stall, so only the queue and a pending pop raise
// busy.
//
// The front classifies each request against the committed pointers, writes
// accepted push bytes into the store right away and queues a command. The
// back turns each command into responses. While a pop is in progress the
// front takes nothing new, so a push can never overwrite a byte that the
// back still has to read.
// ----------------------------------------------------------------------------
module byte_ring_record_buffer import brrb_pkg::*; #(
   parameter int RING_BYTES = RING_BYTES_DEF,
   parameter int MAX_RECORD = MAX_RECORD_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int PTR_W = $clog2(RING_BYTES);

   // Front to queue.
   logic    enq;
   cmd_type enq_cmd;

   // Queue to back.
   cmd_type head_cmd;
   logic    queue_empty;
   logic    queue_full;
   logic    deq;

   // The back tells the front when the last byte of a pop has been read.
   logic pop_done;

   // Store ports: the front writes, the back reads.
   logic             ram_we;
   logic [PTR_W-1:0] ram_waddr;
   logic [7:0]       ram_wdata;
   logic             ram_re;
   logic [PTR_W-1:0] ram_raddr;
   logic [7:0]       ram_q;

   brrb_front #(
      .RING_BYTES (RING_BYTES),
      .MAX_RECORD (MAX_RECORD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .queue_full (queue_full),
      .pop_done   (pop_done),
      .enq        (enq),
      .enq_cmd    (enq_cmd),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata)
   );

   brrb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (enq),
      .push_cmd (enq_cmd),
      .pop      (deq),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   brrb_back #(
      .RING_BYTES (RING_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .deq         (deq),
      .pop_done    (pop_done),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_q       (ram_q),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

   brrb_ram #(
      .WIDTH (8),
      .DEPTH (RING_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

endmodule

[rtl/brrb_checker.sv]
// ----------------------------------------------------------------------------
// brrb_checker
// Port-level checks of the byte ring record buffer, bound to the top level.
// ----------------------------------------------------------------------------
module brrb_checker import brrb_pkg::*; #(
   parameter int RING_BYTES = RING_BYTES_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // Nothing comes out and nothing is held off in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("response or busy right after reset");

   // A popped byte always carries an ok status.
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.byte_valid |-> rsp_item.status == ST_OK)
      else $error("popped byte with error status");

   // A response without a byte is the only response of its request.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.byte_valid |-> rsp_item.last)
      else $error("single response not marked last");

   // The bytes of one pop come out in consecutive cycles.
   a_pop_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.byte_valid && !rsp_item.last
      |=> rsp_strobe && rsp_item.byte_valid)
      else $error("gap inside a pop burst");

   // Free space and stored count always add up to the ring size.
   a_space_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
      12'(rsp_item.free_space + 13'(rsp_item.stored_count)) == 12'(RING_BYTES))
      else $error("free space and stored count disagree");

endmodule

bind byte_ring_record_buffer brrb_checker #(
   .RING_BYTES (RING_BYTES)
) u_brrb_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

[tb/byte_ring_record_buffer_test.sv]
// ----------------------------------------------------------------------------
// byte_ring_record_buffer_test
// Self-checking bench for the byte ring record buffer. Requests go in through
// the start/busy handshake, and a scoreboard with its own copy of the ring
// predicts every response and compares each strobed response field by field.
// A short directed part covers the special cases, and a random phase of
// mixed records and pops follows.
// ----------------------------------------------------------------------------
module byte_ring_record_buffer_test import brrb_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // -------------------------------------------------------------------------
   // Scoreboard. It keeps its own ring, pointers and record state, and it
   // turns each accepted request into the responses that it must cause.
   // Responses are then matched in order against the oldest prediction.
   // -------------------------------------------------------------------------
   class ring_scoreboard;
      logic [7:0]  ring_bytes [RING_BYTES_DEF];
      int unsigned rd_ptr;
      int unsigned wr_ptr;
      int unsigned stage_ptr;
      int unsigned bytes_left;
      bit          storing;
      rsp_type     expected_q [$];
      int unsigned error_count;

      function new();
         rd_ptr      = 0;
         wr_ptr      = 0;
         stage_ptr   = 0;
         bytes_left  = 0;
         storing     = 1'b0;
         error_count = 0;
      endfunction

      // Committed free space, counting the byte that is always kept empty.
      function int unsigned free_bytes();
         if (wr_ptr >= rd_ptr) return RING_BYTES_DEF - wr_ptr + rd_ptr;
         return rd_ptr - wr_ptr;
      endfunction

      function int unsigned stored_bytes();
         return RING_BYTES_DEF - free_bytes();
      endfunction

      // The occupancy fields reflect the state after the whole request.
      function void queue_rsp(status_type st, logic [7:0] data, logic valid,
                              logic is_last);
         rsp_type e;
         e.status       = st;
         e.data_out     = data;
         e.byte_valid   = valid;
         e.last         = is_last;
         e.free_space   = 13'(free_bytes());
         e.stored_count = 12'(stored_bytes());
         expected_q.push_back(e);
      endfunction

      // Writes at the staged pointer and commits on the final byte.
      function void stage_byte(logic [7:0] b);
         ring_bytes[stage_ptr] = b;
         stage_ptr = (stage_ptr + 1) % RING_BYTES_DEF;
         bytes_left--;
         if (bytes_left == 0) begin
            wr_ptr  = stage_ptr;
            storing = 1'b0;
         end
      endfunction

      function void note_request(req_type r);
         status_type  st;
         int unsigned base;
         st = ST_OK;
         if (r.op == OP_PUSH) begin
            if (r.first) begin
               // A new first byte always ends whatever record was open.
               bytes_left = 0;
               storing    = 1'b0;
               if (r.length == 0 || r.length > MAX_RECORD_DEF) begin
                  st = ST_BAD_LEN;
               end else if (free_bytes() <= r.length) begin
                  bytes_left = r.length - 1;
                  st = ST_NO_ROOM;
               end else begin
                  storing    = 1'b1;
                  stage_ptr  = wr_ptr;
                  bytes_left = r.length;
                  stage_byte(r.data_in);
               end
            end else if (bytes_left == 0) begin
               st = ST_STRAY;
            end else if (storing) begin
               stage_byte(r.data_in);
            end else begin
               bytes_left--;
               st = ST_NO_ROOM;
            end
            queue_rsp(st, 8'h00, 1'b0, 1'b1);
         end else if (r.length == 0) begin
            queue_rsp(ST_OK, 8'h00, 1'b0, 1'b1);
         end else if (r.length > MAX_RECORD_DEF) begin
            queue_rsp(ST_BAD_LEN, 8'h00, 1'b0, 1'b1);
         end else if (stored_bytes() < r.length) begin
            queue_rsp(ST_NO_DATA, 8'h00, 1'b0, 1'b1);
         end else begin
            base   = rd_ptr;
            rd_ptr = (rd_ptr + r.length) % RING_BYTES_DEF;
            for (int i = 0; i < r.length; i++) begin
               queue_rsp(ST_OK, ring_bytes[(base + i) % RING_BYTES_DEF], 1'b1,
                         (i + 1 == r.length));
            end
         end
      endfunction

      function void compare_field(string name, logic [12:0] want, logic [12:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("data_out", want.data_out, got.data_out);
         compare_field("byte_valid", want.byte_valid, got.byte_valid);
         compare_field("last", want.last, got.last);
         compare_field("free_space", want.free_space, got.free_space);
         compare_field("stored_count", want.stored_count, got.stored_count);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block itself. All inputs start at known values.
   // -------------------------------------------------------------------------
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   ring_scoreboard sb = new();
   int             items_sent = 0;
   bit             no_gaps    = 1'b0;

   always #4 clock = ~clock;

   byte_ring_record_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // The receiver cannot stall, so every strobed cycle is one response. The
   // values seen here are those from before the edge, so there is no race
   // with the block's own updates.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_item);
   end

   // -------------------------------------------------------------------------
   // Sender. A request stays on the ports with start high until an edge finds
   // busy low. On return start is still high, so a following request goes
   // back to back. Any pause must go through sender_idle, which lowers start
   // first so that the held request is not taken a second time.
   // -------------------------------------------------------------------------

   // Most gaps are short or absent, and a few are long. In burst mode none
   // are inserted at all.
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Holds start low for at least the given count, and waits on the clock even
   // for zero. With until_drained it also waits until every predicted response
   // has arrived, bounded so that a hung block still reaches the final report.
   task automatic sender_idle(int cycles, bit until_drained);
      int n;
      n = 0;
      start <= 1'b0;
      do begin
         @(posedge clock);
         n++;
      end while (n < cycles ||
                 (until_drained && sb.expected_q.size() != 0 && n < 20000));
   endtask

   task automatic send_request(logic op, logic [6:0] len, logic first,
                               logic [7:0] data);
      req_type r;
      int      gap;
      r.op      = op;
      r.length  = len;
      r.first   = first;
      r.data_in = data;
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy !== 1'b0);
      // Accepted at this edge: start was high and busy was low before it.
      sb.note_request(r);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) sender_idle(gap, 1'b0);
   endtask

   // Sends the first byte of a record that claims len bytes and then
   // count-1 further bytes. A count short of len leaves the record open.
   // The length field of the later bytes is ignored by the block, so it is
   // randomized there.
   task automatic push_record(int len, int count);
      send_request(OP_PUSH, 7'(len), 1'b1, 8'($urandom));
      for (int i = 1; i < count; i++) begin
         send_request(OP_PUSH, 7'($urandom_range(0, 127)), 1'b0, 8'($urandom));
      end
   endtask

   // The first and data fields mean nothing to a pop and are left random.
   task automatic pop_bytes(int len);
      send_request(OP_POP, 7'(len), 1'($urandom), 8'($urandom));
   endtask

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin
      int r;
      int stored;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: the field extremes and every special case, one by one.
      send_request(OP_PUSH, 7'd1, 1'b1, 8'hFF);      // single byte record
      pop_bytes(1);
      send_request(OP_PUSH, 7'd2, 1'b1, 8'h00);
      send_request(OP_PUSH, 7'h7F, 1'b0, 8'hA5);     // length ignored here
      pop_bytes(0);                                   // zero length pop
      pop_bytes(MAX_RECORD_DEF + 1);                  // pop length too large
      pop_bytes(127);
      pop_bytes(3);                                   // only two bytes stored
      pop_bytes(2);
      send_request(OP_PUSH, 7'd0, 1'b1, 8'h5A);       // bad record lengths
      send_request(OP_PUSH, 7'(MAX_RECORD_DEF + 1), 1'b1, 8'h3C);
      send_request(OP_PUSH, 7'd127, 1'b1, 8'hC3);
      send_request(OP_PUSH, 7'd9, 1'b0, 8'h81);       // stray byte
      // A new first byte in the middle of a record drops the staged bytes.
      push_record(3, 2);
      push_record(2, 2);
      // A bad length in the middle of a record also ends it, so the next
      // non-first byte is a stray.
      push_record(4, 1);
      send_request(OP_PUSH, 7'd0, 1'b1, 8'h11);
      send_request(OP_PUSH, 7'd4, 1'b0, 8'h22);
      // A pop in the middle of a record sees only committed bytes and does
      // not disturb the open record.
      push_record(4, 2);
      pop_bytes(2);
      send_request(OP_PUSH, 7'd0, 1'b0, 8'h33);
      send_request(OP_PUSH, 7'd0, 1'b0, 8'h44);
      pop_bytes(4);

      // Let the block settle completely before the random part.
      sender_idle(1, 1'b1);

      // Random: mostly complete records and pops with random contents, with
      // broken records, strays and bad lengths mixed in.
      while (items_sent < 150) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            if ($urandom_range(0, 9) < 8) r = $urandom_range(1, 8);
            else r = $urandom_range(1, MAX_RECORD_DEF);
            push_record(r, r);
         end else if (r < 74) begin
            stored = sb.stored_bytes();
            if (stored > 0 && $urandom_range(0, 9) < 7) begin
               pop_bytes($urandom_range(1, (stored > 16) ? 16 : stored));
            end else if ($urandom_range(0, 9) < 8) begin
               pop_bytes($urandom_range(0, 20));
            end else begin
               pop_bytes($urandom_range(0, 127));
            end
         end else if (r < 82) begin
            r = $urandom_range(2, 10);
            push_record(r, $urandom_range(1, r - 1));
         end else if (r < 88) begin
            send_request(OP_PUSH, 7'($urandom_range(0, 127)), 1'b0, 8'($urandom));
         end else if (r < 94) begin
            if ($urandom_range(0, 1)) r = 0;
            else r = $urandom_range(MAX_RECORD_DEF + 1, 127);
            send_request(OP_PUSH, 7'(r), 1'b1, 8'($urandom));
         end else if (r < 97) begin
            // Switch between stretches with and without gaps.
            no_gaps = !no_gaps;
         end else begin
            sender_idle(1, 1'b1);
         end
      end

      // Wait for the last responses, then a while longer so that anything
      // the block might still emit on its own is caught.
      sender_idle(1, 1'b1);
      sender_idle(MAX_RECORD_DEF + 16, 1'b0);
      if (sb.expected_q.size() != 0) begin
         $display("%0t: %0d responses expected, actual none", $time, sb.expected_q.size());
         sb.error_count++;
      end
      if (sb.error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule

[byte_ring_record_buffer.f]
rtl/brrb_pkg.sv
rtl/brrb_ram.sv
rtl/brrb_queue.sv
rtl/brrb_front.sv
rtl/brrb_back.sv
rtl/byte_ring_record_buffer.sv
rtl/brrb_checker.sv
tb/byte_ring_record_buffer_test.sv
